@@ design/lkv_pkg.sv @@
`timescale 1ns / 1ps
package lkv_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic rd_idx;
    logic rd_last;
    logic ev_do;
    logic hit;
    logic miss;
    logic ins_upd;
    logic ins_add;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       gt_cap;
    logic       ge_cap;
    logic       cap_zero;
    logic       idx_lt_count;
    logic       rank_match;
    logic       key_match;
  } sts_t;

endpackage

@@ design/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                   Moves on
// input     start, busy, in_op, in_key_*, in_value_*  start high, busy low
// result    out_valid, out_found, out_word*, counts   out_valid high, one cycle
// config    cfg_we, cfg_wdata                       cfg_we high
//
// One beat at a time. A lookup or insert scans stored keys one entry at a time,
// reading and then comparing each, through the single read port of the
// key/value memory; a new key is written in a separate state after the scan. Each
// eviction adds a rank search for the oldest entry and a copy of the last
// entry into the freed slot, and an eviction made to trim the store to capacity
// adds a recheck of the count. busy falls after the result cycle. Synchronous
// reset empties the store. Results cannot stall.
module lru_key_value_cache #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  input  logic [63:0] in_value_word0,
  input  logic [63:0] in_value_word1,
  input  logic [63:0] in_value_word2,
  input  logic [63:0] in_value_word3,
  output logic        out_valid,
  output logic        out_found,
  output logic [63:0] out_word0,
  output logic [63:0] out_word1,
  output logic [63:0] out_word2,
  output logic [63:0] out_word3,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_eviction_count,
  output logic [5:0]  out_entry_count,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);
  import lkv_pkg::*;

  cmd_t         cmd;
  sts_t         sts;
  logic [255:0] value;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkv_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_key         ({in_key_word3, in_key_word2, in_key_word1, in_key_word0}),
    .in_value       ({in_value_word3, in_value_word2, in_value_word1, in_value_word0}),
    .found          (out_found),
    .out_value      (value),
    .hit_count      (out_hit_count),
    .miss_count     (out_miss_count),
    .eviction_count (out_eviction_count),
    .entry_count    (out_entry_count)
  );

  assign out_word0 = value[63:0];
  assign out_word1 = value[127:64];
  assign out_word2 = value[191:128];
  assign out_word3 = value[255:192];

endmodule

@@ design/lkv_ctrl.sv @@
`timescale 1ns / 1ps
module lkv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  lkv_pkg::sts_t sts,
  output lkv_pkg::cmd_t cmd
);
  import lkv_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_TRIM     = 10'b0000000010,
    S_EV_SCAN  = 10'b0000000100,
    S_EV_READ  = 10'b0000001000,
    S_EV_WRITE = 10'b0000010000,
    S_DISPATCH = 10'b0000100000,
    S_F_RD     = 10'b0001000000,
    S_F_CMP    = 10'b0010000000,
    S_INS_ADD  = 10'b0100000000,
    S_RESP     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_ins_r, ret_ins_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_ins_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_ins_r <= ret_ins_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt   = state_r;
    ret_ins_nxt = ret_ins_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        if (sts.gt_cap) begin
          cmd.idx_clr = 1'b1;
          ret_ins_nxt = 1'b0;
          state_nxt   = S_EV_SCAN;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end
      S_EV_SCAN: begin
        if (sts.rank_match) state_nxt = S_EV_READ;
        else cmd.idx_inc = 1'b1;
      end
      S_EV_READ: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_EV_WRITE;
      end
      S_EV_WRITE: begin
        cmd.ev_do = 1'b1;
        state_nxt = ret_ins_r ? S_INS_ADD : S_TRIM;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_LOOKUP: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_F_RD;
          end
          OP_INSERT: begin
            if (sts.cap_zero) begin
              state_nxt = S_RESP;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_F_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clr   = 1'b1;
            state_nxt = S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_F_RD: begin
        if (sts.idx_lt_count) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_F_CMP;
        end else if (sts.op == OP_LOOKUP) begin
          cmd.miss  = 1'b1;
          state_nxt = S_RESP;
        end else if (sts.ge_cap) begin
          // Room is made by evicting the oldest entry before the new one goes in.
          cmd.idx_clr = 1'b1;
          ret_ins_nxt = 1'b1;
          state_nxt   = S_EV_SCAN;
        end else begin
          state_nxt = S_INS_ADD;
        end
      end
      S_F_CMP: begin
        if (sts.key_match) begin
          if (sts.op == OP_LOOKUP) cmd.hit = 1'b1;
          else cmd.ins_upd = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_F_RD;
        end
      end
      S_INS_ADD: begin
        cmd.ins_add = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ design/lkv_dp.sv @@
`timescale 1ns / 1ps
module lkv_dp #(
  parameter int ENTRIES = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lkv_pkg::cmd_t cmd,
  output lkv_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_wdata,
  input  logic [1:0]    in_op,
  input  logic [255:0]  in_key,
  input  logic [255:0]  in_value,
  output logic          found,
  output logic [255:0]  out_value,
  output logic [31:0]   hit_count,
  output logic [31:0]   miss_count,
  output logic [31:0]   eviction_count,
  output logic [5:0]    entry_count
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [255:0] key_mem [ENTRIES];
  logic [255:0] val_mem [ENTRIES];
  logic [IW-1:0] rank_r [ENTRIES];

  logic [5:0]    cap_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    op_r;
  logic [255:0]  key_r, val_r, key_q, val_q;
  logic [255:0]  res_r;
  logic          found_r;
  logic [31:0]   hits_r, miss_r, evict_r;

  logic [31:0]   cap_eff, count32;
  logic [CW-1:0] last;
  logic [IW-1:0] last_a, idx_a, rd_a, wr_a;
  logic          we, re;
  logic [255:0]  wk, wv;
  logic          promote;

  assign cap_eff = (32'(cap_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_r);
  assign count32 = 32'(count_r);
  assign last    = count_r - CW'(1);
  assign last_a  = last[IW-1:0];
  assign idx_a   = idx_r[IW-1:0];

  assign sts.op           = op_r;
  assign sts.gt_cap       = count32 > cap_eff;
  assign sts.ge_cap       = count32 >= cap_eff;
  assign sts.cap_zero     = (cap_eff == 32'd0);
  assign sts.idx_lt_count = idx_r < count_r;
  assign sts.rank_match   = (rank_r[idx_a] == last_a);
  assign sts.key_match    = (key_q == key_r);

  assign re   = cmd.rd_idx | cmd.rd_last;
  assign rd_a = cmd.rd_last ? last_a : idx_a;

  always_comb begin
    we   = 1'b0;
    wr_a = idx_a;
    wk   = key_q;
    wv   = val_q;
    if (cmd.ev_do) begin
      we = (idx_r != last);
    end else if (cmd.ins_upd) begin
      we = 1'b1;
      wk = key_r;
      wv = val_r;
    end else if (cmd.ins_add) begin
      we   = 1'b1;
      wr_a = count_r[IW-1:0];
      wk   = key_r;
      wv   = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_a] <= wk;
      val_mem[wr_a] <= wv;
    end
    if (re) begin
      key_q <= key_mem[rd_a];
      val_q <= val_mem[rd_a];
    end
  end

  assign promote = cmd.hit | cmd.ins_upd;

  // Ranks of the affected slots change together.
  always_ff @(posedge clk) begin
    for (int t = 0; t < ENTRIES; t++) begin
      if (promote) begin
        if (CW'(t) < count_r && rank_r[t] < rank_r[idx_a]) rank_r[t] <= rank_r[t] + IW'(1);
        if (IW'(t) == idx_a) rank_r[t] <= '0;
      end else if (cmd.ins_add) begin
        if (CW'(t) < count_r) rank_r[t] <= rank_r[t] + IW'(1);
        if (IW'(t) == count_r[IW-1:0]) rank_r[t] <= '0;
      end else if (cmd.ev_do && idx_r != last) begin
        if (IW'(t) == idx_a) rank_r[t] <= rank_r[last_a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
      res_r <= '0;
    end else if (cmd.hit) begin
      res_r <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      count_r <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
      hits_r  <= '0;
      miss_r  <= '0;
      evict_r <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
      if (cmd.latch) found_r <= 1'b0;
      else if (promote) found_r <= 1'b1;
      if (cmd.hit && hits_r != '1) hits_r <= hits_r + 32'd1;
      if (cmd.miss && miss_r != '1) miss_r <= miss_r + 32'd1;
      if (cmd.ev_do) begin
        count_r <= last;
        if (evict_r != '1) evict_r <= evict_r + 32'd1;
      end
      if (cmd.ins_add) count_r <= count_r + CW'(1);
      if (cmd.clr) begin
        count_r <= '0;
        hits_r  <= '0;
        miss_r  <= '0;
        evict_r <= '0;
      end
    end
  end

  assign found          = found_r;
  assign out_value      = res_r;
  assign hit_count      = hits_r;
  assign miss_count     = miss_r;
  assign eviction_count = evict_r;
  assign entry_count    = 6'(count_r);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import lkv_pkg::*;

  localparam int ENTRIES = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        found;
    logic [63:0] word [4];
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
    logic [5:0]  entries;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = OP_LOOKUP;
  logic [63:0] in_key_word0 = '0, in_key_word1 = '0, in_key_word2 = '0, in_key_word3 = '0;
  logic [63:0] in_value_word0 = '0, in_value_word1 = '0;
  logic [63:0] in_value_word2 = '0, in_value_word3 = '0;
  logic        out_valid, out_found;
  logic [63:0] out_word0, out_word1, out_word2, out_word3;
  logic [31:0] out_hit_count, out_miss_count, out_eviction_count;
  logic [5:0]  out_entry_count;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state.
  logic [255:0] mdl_keys [ENTRIES];
  logic [255:0] mdl_vals [ENTRIES];
  int           mdl_rank [ENTRIES];
  int           mdl_count;
  logic [31:0]  mdl_hits, mdl_misses, mdl_evicts;
  int           mdl_capacity;

  cache_result_t pending_results[$];
  int           mismatches = 0;
  bit           timed_out = 0;
  longint       cycles = 0;
  int           idle_pct = 0;
  logic [255:0] key_pool [16];

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void drop_oldest();
    int last, s;
    if (mdl_count == 0) return;
    last = mdl_count - 1;
    for (s = 0; s < mdl_count; s++) if (mdl_rank[s] == last) break;
    if (s < mdl_count && s != last) begin
      mdl_keys[s] = mdl_keys[last];
      mdl_vals[s] = mdl_vals[last];
      mdl_rank[s] = mdl_rank[last];
    end
    mdl_count = last;
    mdl_evicts = sat_inc(mdl_evicts);
  endfunction

  function automatic void make_recent(int s);
    int r;
    r = mdl_rank[s];
    for (int t = 0; t < mdl_count; t++) if (mdl_rank[t] < r) mdl_rank[t]++;
    mdl_rank[s] = 0;
  endfunction

  function automatic int find_slot(logic [255:0] k);
    int s;
    for (s = 0; s < mdl_count; s++) if (mdl_keys[s] == k) break;
    return s;
  endfunction

  function automatic cache_result_t predict_cache(logic [1:0] op, logic [255:0] k,
                                                  logic [255:0] v);
    cache_result_t r;
    logic [255:0] data;
    int cap, s;
    data = '0;
    r.found = 1'b0;
    cap = (mdl_capacity > ENTRIES) ? ENTRIES : mdl_capacity;
    while (mdl_count > cap) drop_oldest();
    case (op)
      OP_LOOKUP: begin
        s = find_slot(k);
        if (s < mdl_count) begin
          make_recent(s);
          data = mdl_vals[s];
          mdl_hits = sat_inc(mdl_hits);
          r.found = 1'b1;
        end else begin
          mdl_misses = sat_inc(mdl_misses);
        end
      end
      OP_INSERT: begin
        if (cap != 0) begin
          s = find_slot(k);
          if (s < mdl_count) begin
            mdl_vals[s] = v;
            make_recent(s);
            r.found = 1'b1;
          end else begin
            if (mdl_count >= cap) drop_oldest();
            for (int t = 0; t < mdl_count; t++) mdl_rank[t]++;
            s = mdl_count;
            if (s < ENTRIES) begin
              mdl_keys[s] = k;
              mdl_vals[s] = v;
              mdl_rank[s] = 0;
              mdl_count = s + 1;
            end
          end
        end
      end
      OP_CLEAR: begin
        mdl_count = 0;
        mdl_hits = '0;
        mdl_misses = '0;
        mdl_evicts = '0;
      end
      default: ;
    endcase
    for (int w = 0; w < 4; w++) r.word[w] = data[64*w +: 64];
    r.hits = mdl_hits;
    r.misses = mdl_misses;
    r.evictions = mdl_evicts;
    r.entries = 6'(mdl_count);
    return r;
  endfunction

  task automatic send_command(logic [1:0] op, logic [255:0] k, logic [255:0] v);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_op <= op;
    {in_key_word3, in_key_word2, in_key_word1, in_key_word0} <= k;
    {in_value_word3, in_value_word2, in_value_word1, in_value_word0} <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_cache(op, k, v));
    start <= 1'b0;
    // The block stays busy after taking a beat, so dropping start here costs nothing.
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(int cap);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= 6'(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_capacity = cap;
  endtask

  function automatic logic [255:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is a beat.
  always @(posedge clk) begin
    cache_result_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = pending_results.pop_front();
        if (out_found !== e.found || out_word0 !== e.word[0] || out_word1 !== e.word[1] ||
            out_word2 !== e.word[2] || out_word3 !== e.word[3] ||
            out_hit_count !== e.hits || out_miss_count !== e.misses ||
            out_eviction_count !== e.evictions || out_entry_count !== e.entries) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp f=%0b w=%h_%h_%h_%h h=%0d m=%0d e=%0d n=%0d",
                     e.found, e.word[3], e.word[2], e.word[1], e.word[0], e.hits,
                     e.misses, e.evictions, e.entries);
            $display("  got f=%0b w=%h_%h_%h_%h h=%0d m=%0d e=%0d n=%0d",
                     out_found, out_word3, out_word2, out_word1, out_word0,
                     out_hit_count, out_miss_count, out_eviction_count,
                     out_entry_count);
          end
        end
      end
    end
    if (cycles >= CYCLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [255:0] ones;
    ones = '1;
    send_command(OP_INSERT, ones, ones);       // capacity zero: ignored
    send_command(OP_LOOKUP, ones, '0);
    set_capacity(2);
    send_command(OP_INSERT, '0, ones);
    send_command(OP_INSERT, ones, '0);
    send_command(OP_LOOKUP, '0, '0);
    send_command(OP_INSERT, {4{64'h5555_AAAA_5555_AAAA}}, ones); // evicts oldest
    send_command(OP_LOOKUP, ones, '0);
    send_command(OP_INSERT, '0, {4{64'h1234_5678_9ABC_DEF0}});   // refresh
    send_command(OP_LOOKUP, '0, '0);
    send_command(2'd3, ones, ones);           // unused op
    set_capacity(1);                          // trim on next item
    send_command(OP_LOOKUP, '0, '0);
    send_command(OP_CLEAR, '0, '0);
    set_capacity(63);                         // saturates at the entry count
    for (int i = 0; i < 34; i++) send_command(OP_INSERT, 256'(i) << (i * 7), rand_wide());
    set_capacity(0);
    send_command(OP_CLEAR, '0, '0);           // trim evictions then cleared
  endtask

  task automatic test_random(int items, int pct);
    logic [255:0] k;
    int r;
    idle_pct = pct;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(199) == 0) set_capacity($urandom_range(63));
      r = $urandom_range(99);
      k = ($urandom_range(3) == 0) ? rand_wide() : key_pool[$urandom_range(15)];
      if (r < 50) send_command(OP_LOOKUP, k, rand_wide());
      else if (r < 96) send_command(OP_INSERT, k, rand_wide());
      else if (r < 98) send_command(OP_CLEAR, k, rand_wide());
      else send_command(2'd3, k, rand_wide());
    end
    idle_pct = 0;
  endtask

  initial begin
    mdl_count = 0;
    mdl_hits = '0;
    mdl_misses = '0;
    mdl_evicts = '0;
    mdl_capacity = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = rand_wide();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_capacity(8);
    test_random(380, 0);
    set_capacity(32);
    test_random(380, 48);
    drain_results();                          // sender holds until all results land
    set_capacity(3);
    test_random(380, 0);
    set_capacity(12);
    test_random(380, 20);
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
